// File: src/pit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants for the point-in-tube test block.
// ----------------------------------------------------------------------------
package pit_pkg;

  // Default capacity of the sample list
  localparam int MAX_SAMPLES_DEF = 256;

  // Field widths
  localparam int COORD_W = 16;
  localparam int CNT_OUT_W = 9;
  localparam int SQ_W = 2 * COORD_W;      // one squared axis difference
  localparam int DIST_W = SQ_W + 2;       // sum of three squares

  // Command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // One stored sample: center and radius
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [COORD_W-1:0] r;
  } sample_t;

  // Flags that travel with a sample down the distance pipeline
  typedef struct packed {
    logic valid;
    logic first;
  } stage_t;

endpackage

// File: src/pit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface pit_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic signed [15:0] pz;
  logic [15:0]        radius;

  modport source (output valid, cmd, px, py, pz, radius, input ready);
  modport sink (input valid, cmd, px, py, pz, radius, output ready);
endinterface

interface pit_out_if;
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic       status;
  logic [8:0] sample_count;

  modport source (output valid, inside_res, status, sample_count, input ready);
  modport sink (input valid, inside_res, status, sample_count, output ready);
endinterface

// File: src/pit_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module pit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/pit_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_dist
// Two-stage squared-distance pipeline: squares, then the three-way sum.
// ----------------------------------------------------------------------------
module pit_dist (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [pit_pkg::COORD_W-1:0]     qx,
  input  logic signed [pit_pkg::COORD_W-1:0]     qy,
  input  logic signed [pit_pkg::COORD_W-1:0]     qz,
  input  pit_pkg::sample_t                       rdata,
  input  pit_pkg::stage_t                        in_flag,
  output logic [pit_pkg::DIST_W-1:0]             sq_dist,
  output logic [pit_pkg::SQ_W-1:0]               r2,
  output logic                                   mid_valid,
  output pit_pkg::stage_t                        out_flag
);

  // |a - b|, always fits the unsigned coordinate width
  function automatic logic [pit_pkg::COORD_W-1:0] abs_diff(
    input logic signed [pit_pkg::COORD_W-1:0] a,
    input logic signed [pit_pkg::COORD_W-1:0] b
  );
    logic signed [pit_pkg::COORD_W:0] d;
    logic signed [pit_pkg::COORD_W:0] n;
    begin
      d = {a[pit_pkg::COORD_W-1], a} - {b[pit_pkg::COORD_W-1], b};
      n = -d;
      abs_diff = d[pit_pkg::COORD_W] ? n[pit_pkg::COORD_W-1:0]
                                     : d[pit_pkg::COORD_W-1:0];
    end
  endfunction

  logic [pit_pkg::COORD_W-1:0] ax, ay, az;
  logic [pit_pkg::SQ_W-1:0]    sq_x, sq_y, sq_z, sq_r;
  pit_pkg::stage_t             flag_a;

  assign ax = abs_diff(qx, rdata.x);
  assign ay = abs_diff(qy, rdata.y);
  assign az = abs_diff(qz, rdata.z);

  // a sample sits between the two stages
  assign mid_valid = flag_a.valid;

  // stage A: squares of the axis differences and of the radius
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_a <= '0;
    end else begin
      flag_a <= in_flag;
    end
    sq_x <= ax * ax;
    sq_y <= ay * ay;
    sq_z <= az * az;
    sq_r <= rdata.r * rdata.r;
  end

  // stage B: squared distance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_flag <= '0;
    end else begin
      out_flag <= flag_a;
    end
    sq_dist <= {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
    r2      <= sq_r;
  end

endmodule

// File: src/point_in_tube_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_tube_test
// Tube sample list with bounding box and nearest-center point query.
// ----------------------------------------------------------------------------
// Every command word returns one result word. Clear, append, the unused
// command and a query that misses the center box or meets an empty list
// are answered straight from the idle state. Any other query reads the
// sample memory through its single read port, one sample per cycle; the
// steps are memory read, square, sum, compare and the final test.
// The block takes the next word once it is idle and its result register is
// empty or being drained. The sample memory holds no reset value; only
// entries below the held count are ever read.
// ----------------------------------------------------------------------------
module point_in_tube_test #(
  parameter int MAX_SAMPLES = pit_pkg::MAX_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pit_in_if.sink    in_ch,
  pit_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t state;

  // Held list state
  logic [CW-1:0]                      count;
  logic signed [pit_pkg::COORD_W-1:0] lo_x, lo_y, lo_z;
  logic signed [pit_pkg::COORD_W-1:0] hi_x, hi_y, hi_z;

  // Query state
  logic signed [pit_pkg::COORD_W-1:0] qx, qy, qz;
  logic [CW-1:0]                      issue_idx;
  pit_pkg::stage_t                    rd_flag;
  logic [pit_pkg::DIST_W-1:0]         best_d;
  logic [pit_pkg::SQ_W-1:0]           best_r2;

  // Result register
  logic                               out_valid;
  logic                               out_inside;
  logic                               out_status;
  logic [pit_pkg::CNT_OUT_W-1:0]      out_count;

  // Memory and pipeline wiring
  logic                               in_acc;
  logic                               full;
  logic                               outside;
  logic                               issue;
  logic                               ram_we;
  pit_pkg::sample_t                   wsample;
  pit_pkg::sample_t                   rsample;
  logic [pit_pkg::DIST_W-1:0]         sq_dist;
  logic [pit_pkg::SQ_W-1:0]           r2;
  logic                               mid_valid;
  pit_pkg::stage_t                    dist_flag;
  logic [CW+pit_pkg::CNT_OUT_W-1:0]   count_ext;
  logic [CW+pit_pkg::CNT_OUT_W-1:0]   count_inc_ext;

  assign in_ch.ready = (state == IDLE) && (!out_valid || out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign full = (count >= CW'(MAX_SAMPLES));

  // Inclusive center box test on the incoming point
  assign outside = (in_ch.px < lo_x) || (in_ch.px > hi_x) ||
                   (in_ch.py < lo_y) || (in_ch.py > hi_y) ||
                   (in_ch.pz < lo_z) || (in_ch.pz > hi_z);

  assign ram_we = in_acc && (in_ch.cmd == pit_pkg::CMD_APPEND) && !full;
  assign wsample = '{x: in_ch.px, y: in_ch.py, z: in_ch.pz, r: in_ch.radius};
  assign issue = (state == SCAN) && (issue_idx != count);

  // Output count masked to the result field
  assign count_ext = {{pit_pkg::CNT_OUT_W{1'b0}}, count};
  assign count_inc_ext = count_ext + 1'b1;

  pit_ram #(
    .WIDTH($bits(pit_pkg::sample_t)),
    .DEPTH(MAX_SAMPLES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(wsample),
    .raddr(issue_idx[AW-1:0]),
    .rdata(rsample)
  );

  pit_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .rdata    (rsample),
    .in_flag  (rd_flag),
    .sq_dist  (sq_dist),
    .r2       (r2),
    .mid_valid(mid_valid),
    .out_flag (dist_flag)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.inside_res   = out_inside;
  assign out_ch.status       = out_status;
  assign out_ch.sample_count = out_count;

  // Command sequencer, list state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      lo_x      <= 16'sh7fff;
      lo_y      <= 16'sh7fff;
      lo_z      <= 16'sh7fff;
      hi_x      <= 16'sh8000;
      hi_y      <= 16'sh8000;
      hi_z      <= 16'sh8000;
      rd_flag   <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      // memory read issue, one sample per cycle
      rd_flag.valid <= issue;
      rd_flag.first <= (issue_idx == '0);
      if (issue) begin
        issue_idx <= issue_idx + 1'b1;
      end

      // keep the nearest center, earliest wins ties
      if (dist_flag.valid && (dist_flag.first || (sq_dist < best_d))) begin
        best_d  <= sq_dist;
        best_r2 <= r2;
      end

      unique case (state)
        IDLE: begin
          if (in_acc) begin
            out_inside <= 1'b0;
            out_status <= 1'b0;
            out_count  <= count_ext[pit_pkg::CNT_OUT_W-1:0];
            out_valid  <= 1'b1;
            unique case (in_ch.cmd)
              pit_pkg::CMD_CLEAR: begin
                count     <= '0;
                out_count <= '0;
                lo_x      <= 16'sh7fff;
                lo_y      <= 16'sh7fff;
                lo_z      <= 16'sh7fff;
                hi_x      <= 16'sh8000;
                hi_y      <= 16'sh8000;
                hi_z      <= 16'sh8000;
              end
              pit_pkg::CMD_APPEND: begin
                if (full) begin
                  out_status <= 1'b1;
                end else begin
                  count     <= count + 1'b1;
                  out_count <= count_inc_ext[pit_pkg::CNT_OUT_W-1:0];
                  if (in_ch.px < lo_x) lo_x <= in_ch.px;
                  if (in_ch.py < lo_y) lo_y <= in_ch.py;
                  if (in_ch.pz < lo_z) lo_z <= in_ch.pz;
                  if (in_ch.px > hi_x) hi_x <= in_ch.px;
                  if (in_ch.py > hi_y) hi_y <= in_ch.py;
                  if (in_ch.pz > hi_z) hi_z <= in_ch.pz;
                end
              end
              pit_pkg::CMD_QUERY: begin
                if ((count != '0) && !outside) begin
                  out_valid <= 1'b0;
                  qx        <= in_ch.px;
                  qy        <= in_ch.py;
                  qz        <= in_ch.pz;
                  issue_idx <= '0;
                  state     <= SCAN;
                end
              end
              default: begin
                // unused command: report current count only
              end
            endcase
          end
        end
        SCAN: begin
          // all reads issued and the pipeline drained
          if (!issue && !rd_flag.valid && !mid_valid && !dist_flag.valid) begin
            out_inside <= (best_d <= {2'b00, best_r2});
            out_status <= 1'b0;
            out_count  <= count_ext[pit_pkg::CNT_OUT_W-1:0];
            out_valid  <= 1'b1;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
